>>> rtl/crc16pc_pkg.sv
// Package with the shared constants and the CRC byte update of the packet checker.
`timescale 1ns / 1ps

package crc16pc_pkg;

  localparam int unsigned PACKET_LEN_DEF = 21;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int unsigned POS_TYPE    = 0;
  localparam int unsigned POS_SEQ     = 1;
  localparam int unsigned POS_CRC_LO  = 2;
  localparam int unsigned POS_CRC_HI  = 3;
  localparam int unsigned POS_PAYLOAD = 4;

  localparam int unsigned OUT_DATA_W = 64;

  // One byte of CRC-16 with polynomial 0x1021, no reflection.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  x;
    logic [15:0] r;
    x = crc[15:8] ^ b;
    x = x ^ (x >> 4);
    r = {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
    return r;
  endfunction

endpackage

>>> rtl/crc16_packet_checker_top.sv
// Streaming CRC-16 packet checker: header capture, checksum build and check.
`timescale 1ns / 1ps

// The block takes one packet byte per item on the s_ side and sustains one item per
// cycle. Each byte first lands in an input register; the CRC byte update and header
// capture then run combinationally into the running state, and on the packet's last
// byte the result item is loaded into the output register, so a packet's last byte
// passes the input register and then the output register on its way to the result.
// The input side stalls only when a packet ends while the previous result still sits
// unread in the output register. Setting s_tuser marks a byte as the first of a new
// packet and discards any partial one; after PACKET_LEN bytes the next byte starts a
// new packet on its own. Bytes 2 and 3 enter the CRC as zero, so computed_checksum
// serves for building and checksum_ok for checking.
module crc16_packet_checker_top #(
  parameter int unsigned PACKET_LEN = crc16pc_pkg::PACKET_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // data_byte
  input  logic                                s_tuser,  // first_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // computed_checksum[15:0], checksum_ok[16], stored_checksum[32:17], msg_type[40:33],
  // seq_number[48:41], msg_payload[56:49], zero fill[63:57]
  output logic [crc16pc_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import crc16pc_pkg::*;

  localparam int unsigned PosW = $clog2(PACKET_LEN);

  logic            in_valid;
  logic [7:0]      in_byte;
  logic            in_first;

  logic [15:0]     crc_reg;
  logic [PosW-1:0] byte_pos;
  logic [15:0]     expected_crc;
  logic [7:0]      type_hold;
  logic [7:0]      seq_hold;
  logic [7:0]      payload_hold;

  logic [PosW-1:0] pos_cur;
  logic [7:0]      fed;
  logic [15:0]     crc_base;
  logic [15:0]     crc_new;
  logic [15:0]     expected_crc_next;
  logic [7:0]      type_hold_next;
  logic [7:0]      seq_hold_next;
  logic [7:0]      payload_hold_next;
  logic            is_last;
  logic            out_free;
  logic            advance;

  always_comb begin
    pos_cur           = in_first ? '0 : byte_pos;
    crc_base          = in_first ? CRC_INIT : crc_reg;
    fed               = in_byte;
    expected_crc_next = expected_crc;
    type_hold_next    = type_hold;
    seq_hold_next     = seq_hold;
    payload_hold_next = payload_hold;
    if (pos_cur == PosW'(POS_TYPE)) begin
      type_hold_next = in_byte;
    end
    if (pos_cur == PosW'(POS_SEQ)) begin
      seq_hold_next = in_byte;
    end
    if (pos_cur == PosW'(POS_CRC_LO)) begin
      expected_crc_next = {expected_crc[15:8], in_byte};
      fed               = 8'h00;
    end
    if (pos_cur == PosW'(POS_CRC_HI)) begin
      expected_crc_next = {in_byte, expected_crc[7:0]};
      fed               = 8'h00;
    end
    if (pos_cur == PosW'(POS_PAYLOAD)) begin
      payload_hold_next = in_byte;
    end
    crc_new  = crc_update(crc_base, fed);
    is_last  = (pos_cur == PosW'(PACKET_LEN - 1));
    out_free = !m_tvalid || m_tready;
    advance  = in_valid && (!is_last || out_free);
  end

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg  <= CRC_INIT;
      byte_pos <= '0;
    end else if (advance) begin
      if (is_last) begin
        crc_reg  <= CRC_INIT;
        byte_pos <= '0;
      end else begin
        crc_reg  <= crc_new;
        byte_pos <= pos_cur + PosW'(1);
      end
    end
    if (advance) begin
      expected_crc <= expected_crc_next;
      type_hold    <= type_hold_next;
      seq_hold     <= seq_hold_next;
      payload_hold <= payload_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && is_last;
    end
    if (advance && is_last) begin
      m_tdata <= {7'b0000000, payload_hold_next, seq_hold_next, type_hold_next,
                  expected_crc_next, crc_new == expected_crc_next, crc_new};
    end
  end

  a_pos_range : assert property (@(posedge clk) disable iff (rst)
    byte_pos <= PosW'(PACKET_LEN - 1))
    else $error("byte position ran past the packet end");

  a_last_gives_result : assert property (@(posedge clk) disable iff (rst)
    advance && is_last |=> m_tvalid)
    else $error("last byte did not produce a result item");

  a_restart_after_last : assert property (@(posedge clk) disable iff (rst)
    advance && is_last |=> byte_pos == '0 && crc_reg == CRC_INIT)
    else $error("packet state not restarted after last byte");

  a_in_reg_holds : assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte) && $stable(in_first))
    else $error("stalled input register was overwritten");

  a_no_result_mid_packet : assert property (@(posedge clk) disable iff (rst)
    advance && !is_last && !m_tvalid |=> !m_tvalid)
    else $error("result item appeared without a packet end");

endmodule
